[src/assert_macros.svh]
// Assertion macros for the sort-then-zig-zag block.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define STZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that an event is followed by a condition in the next cycle.
`define STZ_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

[src/stz_pkg.sv]
// Shared constants and types for the sort-then-zig-zag block.
// Used by stz_ctrl and sort_then_zigzag_reorder; no dependencies.
package stz_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;

    typedef struct packed {
        logic load;
        logic last;
        logic ovf;
    } stz_emit_t;

endpackage

[src/stz_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module stz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/stz_ctrl.sv]
// Sequencer for load, in-memory insertion sort and zig-zag read-out.
// Depends on stz_pkg; drives the ports of one stz_ram instance.
module stz_ctrl #(
    parameter int MAX_ITEMS = stz_pkg::MAX_ITEMS_DEF,
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [stz_pkg::DATA_W-1:0] s_value,
    input  logic                       s_last,
    input  logic                       out_taken,
    output stz_pkg::stz_emit_t         emit,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_waddr,
    output logic [stz_pkg::DATA_W-1:0] ram_wdata,
    output logic [AW-1:0]              ram_raddr,
    input  logic [stz_pkg::DATA_W-1:0] ram_rdata
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] One    = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY_RD,
        ST_KEY_WAIT,
        ST_CMP,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;
    logic [CNT_W-1:0]            i_reg, i_next;
    logic [CNT_W-1:0]            pos_reg, pos_next;
    logic [stz_pkg::DATA_W-1:0]  key_reg, key_next;

    logic [CNT_W-1:0] i_inc, i_dec, pos_dec, pos_dec2;
    logic [CNT_W-1:0] half, dpos, src_odd, src_raw, src;
    logic             last_pos;

    assign i_inc    = i_reg + One;
    assign i_dec    = i_reg - One;
    assign pos_dec  = pos_reg - One;
    assign pos_dec2 = pos_reg - CNT_W'(2);
    assign last_pos = ((pos_reg + One) == cnt_reg);

    assign half    = cnt_reg >> 1;
    assign dpos    = pos_reg >> 1;
    assign src_odd = ((half - dpos - One) << 1) | One;
    assign src_raw = pos_reg[0] ? src_odd : pos_reg;
    assign src     = (src_raw >= cnt_reg) ? (cnt_reg - One) : src_raw;

    assign s_tready = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;
        emit       = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (cnt_reg < MaxCnt) begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[AW-1:0];
                        ram_wdata = s_value;
                        cnt_next  = cnt_reg + One;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        i_next     = One;
                        pos_next   = '0;
                        state_next = (cnt_next > One) ? ST_KEY_RD : ST_EMIT_RD;
                    end
                end
            end
            ST_KEY_RD: begin
                ram_raddr  = i_reg[AW-1:0];
                state_next = ST_KEY_WAIT;
            end
            ST_KEY_WAIT: begin
                key_next   = ram_rdata;
                pos_next   = i_reg;
                ram_raddr  = i_dec[AW-1:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[AW-1:0];
                if ($signed(key_reg) < $signed(ram_rdata)) begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_dec;
                    if (pos_dec == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        ram_raddr = pos_dec2[AW-1:0];
                    end
                end else begin
                    ram_wdata  = key_reg;
                    i_next     = i_inc;
                    pos_next   = '0;
                    state_next = (i_inc == cnt_reg) ? ST_EMIT_RD : ST_KEY_RD;
                end
            end
            ST_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = key_reg;
                i_next     = i_inc;
                pos_next   = '0;
                state_next = (i_inc == cnt_reg) ? ST_EMIT_RD : ST_KEY_RD;
            end
            ST_EMIT_RD: begin
                ram_raddr  = src[AW-1:0];
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                emit.load  = 1'b1;
                emit.last  = last_pos;
                emit.ovf   = ovf_reg;
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (out_taken) begin
                    if (last_pos) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        pos_next   = pos_reg + One;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            pos_reg   <= pos_next;
        end
        key_reg <= key_next;
    end

endmodule

[src/sort_then_zigzag_reorder.sv]
// Top level of the sort-then-zig-zag block: sequencer, element RAM, result register.
// Depends on stz_pkg, stz_ram, stz_ctrl and assert_macros.svh.
//
// Use: stream list elements in on the s_ channel, one signed 32-bit value per
// transaction, s_tlast on the final element. Up to MAX_ITEMS elements are kept;
// further elements are dropped and the run is flagged with m_tuser.
// A transaction without s_tlast is accepted and yields no result.
// On the closing transaction the list is insertion-sorted in the element RAM:
// each element is read as the key, larger elements before it are shifted up
// one place and the key is written into the gap, paced by the single RAM port pair.
// The list then leaves on the m_ channel in zig-zag order: even positions
// carry the even-ranked values ascending, odd positions the odd-ranked values
// descending, m_tlast on the final one. The next result is read only after the
// previous one has been taken; a stalled receiver holds the result register and the
// sequence. s_tready stays low from the closing transaction until the last
// result has been taken. Reset empties the list and clears the flag; RAM
// contents need no clearing, as only entries of the current list are read.
`include "assert_macros.svh"

module sort_then_zigzag_reorder #(
    parameter int MAX_ITEMS = stz_pkg::MAX_ITEMS_DEF,
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // end_of_list
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic        m_tlast,   // end_of_run
    output logic [0:0]  m_tuser    // [0] overflow
);

    stz_pkg::stz_emit_t         emit;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [stz_pkg::DATA_W-1:0] ram_wdata;
    logic [stz_pkg::DATA_W-1:0] ram_rdata;
    logic                       out_taken;

    logic                       m_valid_reg;
    logic [stz_pkg::DATA_W-1:0] m_data_reg;
    logic                       m_last_reg;
    logic                       m_ovf_reg;

    stz_ram #(
        .WIDTH (stz_pkg::DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stz_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata),
        .s_last    (s_tlast),
        .out_taken (out_taken),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign out_taken = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.load) begin
            m_valid_reg <= 1'b1;
        end else if (out_taken) begin
            m_valid_reg <= 1'b0;
        end
        if (emit.load) begin
            m_data_reg <= ram_rdata;
            m_last_reg <= emit.last;
            m_ovf_reg  <= emit.ovf;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

    `STZ_ASSERT(a_in_out_excl, !(s_tready && m_tvalid), "input ready while a result is pending")
    `STZ_ASSERT_NEXT(a_close_blocks, s_tvalid && s_tready && s_tlast, !s_tready, "close not held")
    `STZ_ASSERT_NEXT(a_run_reopens, m_tvalid && m_tready && m_tlast, s_tready, "run not reopened")
    `STZ_ASSERT_NEXT(a_load_shows, emit.load, m_tvalid, "loaded result not presented")

endmodule
